[rtl/tipe_pkg.sv]
// ----------------------------------------------------------------------------
// tipe_pkg
// shared types, constants and colour tables of the tile image pixel expander
// ----------------------------------------------------------------------------
package tipe_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COORD_W = 13;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned CIDX_W  = 2;

    typedef enum logic [CIDX_W-1:0] {
        CFG_FRAME_SELECT = 2'd0,
        CFG_X_ORIGIN     = 2'd1,
        CFG_Y_ORIGIN     = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [15:0]               mask;
        logic [5:0]                fg_colour;
        logic [1:0]                fg_alpha;
        logic [5:0]                bg_colour;
        logic [1:0]                bg_alpha;
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic                      last_image;
    } t_job;

    localparam logic [7:0] ALPHA_1 = 8'h3d;
    localparam logic [7:0] ALPHA_2 = 8'h80;
    localparam logic [7:0] ALPHA_3 = 8'hff;

    function automatic logic [7:0] alpha_lut(input logic [1:0] code);
        logic [7:0] a;
        unique case (code)
            2'd0:    a = 8'h00;
            2'd1:    a = ALPHA_1;
            2'd2:    a = ALPHA_2;
            default: a = ALPHA_3;
        endcase
        return a;
    endfunction

    // palette: high two bits pick red level, low four bits a green/blue pair,
    // with a grey on the sixteenth entry of each group
    function automatic logic [23:0] palette_lut(input logic [5:0] idx);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] grey;
        unique case (idx[5:4])
            2'd0:    begin r = 8'h00; grey = 8'h3d; end
            2'd1:    begin r = 8'h70; grey = 8'h70; end
            2'd2:    begin r = 8'hc0; grey = 8'ha8; end
            default: begin r = 8'hff; grey = 8'hd7; end
        endcase
        unique case (idx[3:0])
            4'd0:    begin g = 8'h00; b = 8'h00; end
            4'd1:    begin g = 8'h00; b = 8'ha0; end
            4'd2:    begin g = 8'h00; b = 8'hff; end
            4'd3:    begin g = 8'h60; b = 8'h00; end
            4'd4:    begin g = 8'h60; b = 8'ha0; end
            4'd5:    begin g = 8'h60; b = 8'hff; end
            4'd6:    begin g = 8'h9c; b = 8'h00; end
            4'd7:    begin g = 8'h9c; b = 8'ha0; end
            4'd8:    begin g = 8'h9c; b = 8'hff; end
            4'd9:    begin g = 8'hd0; b = 8'h00; end
            4'd10:   begin g = 8'hd0; b = 8'ha0; end
            4'd11:   begin g = 8'hd0; b = 8'hff; end
            4'd12:   begin g = 8'hff; b = 8'h00; end
            4'd13:   begin g = 8'hff; b = 8'ha0; end
            4'd14:   begin g = 8'hff; b = 8'hff; end
            default: begin r = grey; g = grey; b = grey; end
        endcase
        return {r, g, b};
    endfunction

endpackage

[rtl/tipe_front.sv]
// ----------------------------------------------------------------------------
// tipe_front
// config registers, header decode, tile position tracking and job issue
// ----------------------------------------------------------------------------
module tipe_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tipe_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [tipe_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_accept,
    input  logic [tipe_pkg::WORD_W-1:0]   i_image_word,
    input  logic                          i_start_of_image,
    output logic                          o_job_push,
    output tipe_pkg::t_job                o_job
);
    import tipe_pkg::*;

    logic [7:0]  r_frame_select;
    logic [11:0] r_x_origin;
    logic [11:0] r_y_origin;

    logic       r_active;
    logic [7:0] r_wide;
    logic [7:0] r_high;
    logic [7:0] r_col;
    logic [7:0] r_row;
    logic [7:0] r_frame;

    logic n_active;
    logic [7:0] n_wide;
    logic [7:0] n_high;
    logic [7:0] n_col;
    logic [7:0] n_row;
    logic [7:0] n_frame;

    logic last_col;
    logic last_row;
    logic selected;
    logic tile_beat;

    assign last_col  = ({1'b0, r_col} + 9'd1) >= {1'b0, r_wide};
    assign last_row  = ({1'b0, r_row} + 9'd1) >= {1'b0, r_high};
    assign selected  = (r_frame == r_frame_select);
    assign tile_beat = i_accept && !i_start_of_image && r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_select <= '0;
            r_x_origin     <= '0;
            r_y_origin     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_SELECT: r_frame_select <= i_cfg_data[7:0];
                CFG_X_ORIGIN:     r_x_origin     <= i_cfg_data;
                CFG_Y_ORIGIN:     r_y_origin     <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb begin
        n_active = r_active;
        n_wide   = r_wide;
        n_high   = r_high;
        n_col    = r_col;
        n_row    = r_row;
        n_frame  = r_frame;
        if (i_accept && i_start_of_image) begin
            n_high   = i_image_word[7:0];
            n_wide   = i_image_word[15:8];
            n_col    = '0;
            n_row    = '0;
            n_frame  = '0;
            n_active = (i_image_word[7:0] != '0) && (i_image_word[15:8] != '0);
        end else if (tile_beat) begin
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row = '0;
                    if (selected) begin
                        n_active = 1'b0;
                    end else begin
                        n_frame = r_frame + 8'd1;
                    end
                end else begin
                    n_row = r_row + 8'd1;
                end
            end else begin
                n_col = r_col + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_wide   <= '0;
            r_high   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_frame  <= '0;
        end else begin
            r_active <= n_active;
            r_wide   <= n_wide;
            r_high   <= n_high;
            r_col    <= n_col;
            r_row    <= n_row;
            r_frame  <= n_frame;
        end
    end

    assign o_job_push = tile_beat && selected;

    always_comb begin
        o_job.mask       = i_image_word[15:0];
        o_job.fg_colour  = i_image_word[21:16];
        o_job.fg_alpha   = i_image_word[23:22];
        o_job.bg_colour  = i_image_word[29:24];
        o_job.bg_alpha   = i_image_word[31:30];
        o_job.base_x     = COORD_W'($signed({r_x_origin[11], r_x_origin}))
                         + $signed({3'b000, r_col, 2'b00});
        o_job.base_y     = COORD_W'($signed({r_y_origin[11], r_y_origin}))
                         + $signed({3'b000, r_row, 2'b00});
        o_job.last_image = last_col && last_row;
    end

endmodule

[rtl/tipe_queue.sv]
// ----------------------------------------------------------------------------
// tipe_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module tipe_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tipe_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tipe_pkg::t_job o_job
);
    import tipe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_store[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

[rtl/tipe_back.sv]
// ----------------------------------------------------------------------------
// tipe_back
// expands one tile job into sixteen pixels into the output register
// ----------------------------------------------------------------------------
module tipe_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  tipe_pkg::t_job                      i_job,
    output logic                                o_job_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [tipe_pkg::COORD_W-1:0] o_pixel_x,
    output logic signed [tipe_pkg::COORD_W-1:0] o_pixel_y,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue,
    output logic [7:0]                          o_alpha,
    output logic                                o_last_of_tile,
    output logic                                o_last_of_image
);
    import tipe_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_out_valid;

    logic        advance;
    logic        tile_end;
    logic        take;
    logic        on;
    logic [5:0]  colour;
    logic [1:0]  acode;
    logic [23:0] rgb;

    assign advance   = r_busy && (!r_out_valid || pop);
    assign tile_end  = advance && (r_idx == 4'd15);
    assign take      = i_job_valid && (!r_busy || tile_end);
    assign o_job_pop = take;
    assign empty     = !r_out_valid;

    assign on     = r_job.mask[r_idx];
    assign colour = on ? r_job.fg_colour : r_job.bg_colour;
    assign acode  = on ? r_job.fg_alpha : r_job.bg_alpha;
    assign rgb    = palette_lut(colour);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 4'd1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (tile_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        if (advance) begin
            o_pixel_x       <= r_job.base_x + $signed({{(COORD_W-2){1'b0}}, r_idx[1:0]});
            o_pixel_y       <= r_job.base_y + $signed({{(COORD_W-2){1'b0}}, r_idx[3:2]});
            o_red           <= rgb[23:16];
            o_green         <= rgb[15:8];
            o_blue          <= rgb[7:0];
            o_alpha         <= alpha_lut(acode);
            o_last_of_tile  <= (r_idx == 4'd15);
            o_last_of_image <= (r_idx == 4'd15) && r_job.last_image;
        end
    end

endmodule

[rtl/tile_image_pixel_expander.sv]
// ----------------------------------------------------------------------------
// tile_image_pixel_expander
// expands two-colour 4x4 tiles of the selected frame into rgba pixels
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          i_image_word, i_start_of_image
//  result    empty / pop          o_pixel_x/y, o_red/green/blue/alpha, o_last_*
//  config    i_cfg_we             i_cfg_index, i_cfg_data
//
//  a selected tile gives sixteen pixels, one a cycle from the back expander
//  while pop is held; headers and unselected tiles give no pixels
//  the first pixel passes the job queue, the back job register and the
//  output register; the job queue lets the next tile in while the current
//  one drains, and the back takes a waiting tile with the last pixel
//  full rises only when the job queue is full; a stalled pop holds the pixel
//  synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module tile_image_pixel_expander #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tipe_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [tipe_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [tipe_pkg::WORD_W-1:0]         i_image_word,
    input  logic                                i_start_of_image,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [tipe_pkg::COORD_W-1:0] o_pixel_x,
    output logic signed [tipe_pkg::COORD_W-1:0] o_pixel_y,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue,
    output logic [7:0]                          o_alpha,
    output logic                                o_last_of_tile,
    output logic                                o_last_of_image
);
    import tipe_pkg::*;

    logic accept;
    logic job_push;
    t_job front_job;
    logic job_valid;
    logic job_pop;
    t_job back_job;

    assign accept = push && !full;

    tipe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_image_word     (i_image_word),
        .i_start_of_image (i_start_of_image),
        .o_job_push       (job_push),
        .o_job            (front_job)
    );

    tipe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (back_job)
    );

    tipe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (back_job),
        .o_job_pop       (job_pop),
        .empty           (empty),
        .pop             (pop),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_last_of_tile  (o_last_of_tile),
        .o_last_of_image (o_last_of_image)
    );

endmodule

[rtl/tipe_checker.sv]
// ----------------------------------------------------------------------------
// tipe_checker
// port-level checks of the tile image pixel expander
// ----------------------------------------------------------------------------
module tipe_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic signed [tipe_pkg::COORD_W-1:0] o_pixel_x,
    input logic signed [tipe_pkg::COORD_W-1:0] o_pixel_y,
    input logic [7:0]                          o_red,
    input logic [7:0]                          o_alpha,
    input logic                                o_last_of_tile,
    input logic                                o_last_of_image
);
    import tipe_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("outputs not idle after reset");

    a_image_end_in_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last_of_image |-> o_last_of_tile)
        else $error("image end off a tile end");

    a_tile_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_last_of_tile |=> !empty)
        else $error("gap inside a tile");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_red) && $stable(o_alpha) && $stable(o_last_of_tile))
        else $error("stalled beat changed");

endmodule

bind tile_image_pixel_expander tipe_checker u_tipe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_red           (o_red),
    .o_alpha         (o_alpha),
    .o_last_of_tile  (o_last_of_tile),
    .o_last_of_image (o_last_of_image)
);

[tb/tb_tile_image_pixel_expander.sv]
// ----------------------------------------------------------------------------
// tb_tile_image_pixel_expander
// Streams headers and packed 4x4 tiles into the expander and predicts every
// pixel beat, with position, colour, alpha and end flags, from its own copy
// of the image walk and the registers. Directed images cover empty
// dimensions, stray tiles, restarts mid-image, unselected frames, the frame
// counter wrap and the origin extremes. Random images follow, with idle
// bursts on both sides and register changes between drained phases.
// ----------------------------------------------------------------------------
module tb_tile_image_pixel_expander;

    timeunit 1ns;
    timeprecision 1ps;

    import tipe_pkg::*;

    localparam int unsigned LIMIT = 600000;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;
    } image_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [7:0]                r;
        logic [7:0]                g;
        logic [7:0]                b;
        logic [7:0]                a;
        logic                      tile_end;
        logic                      image_end;
    } pixel_t;

    logic                      i_clk;
    logic                      i_rst_n          = 1'b0;
    logic                      i_cfg_we         = 1'b0;
    logic [CIDX_W-1:0]         i_cfg_index      = CFG_FRAME_SELECT;
    logic [CFG_W-1:0]          i_cfg_data       = '0;
    logic                      push             = 1'b0;
    logic                      full;
    logic [WORD_W-1:0]         i_image_word     = '0;
    logic                      i_start_of_image = 1'b0;
    logic                      empty;
    logic                      pop              = 1'b0;
    logic signed [COORD_W-1:0] o_pixel_x;
    logic signed [COORD_W-1:0] o_pixel_y;
    logic [7:0]                o_red;
    logic [7:0]                o_green;
    logic [7:0]                o_blue;
    logic [7:0]                o_alpha;
    logic                      o_last_of_tile;
    logic                      o_last_of_image;

    image_beat_t queued_beats[$];
    pixel_t      due_pixels[$];

    // image walk and register copies
    logic        img_on     = 1'b0;
    logic [7:0]  img_wide   = '0;
    logic [7:0]  img_high   = '0;
    logic [7:0]  tile_col   = '0;
    logic [7:0]  tile_row   = '0;
    logic [7:0]  frame_no   = '0;
    logic [7:0]  sel_frame  = '0;
    logic [11:0] org_x      = '0;
    logic [11:0] org_y      = '0;

    int          send_odds  = 3;
    int          take_odds  = 3;
    int          send_gap   = 0;
    int          take_gap   = 0;
    int          mismatches = 0;
    int          leftover   = 0;
    int          rand_words = 0;
    int unsigned cycles     = 0;

    tile_image_pixel_expander u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_image_word    (i_image_word),
        .i_start_of_image(i_start_of_image),
        .empty           (empty),
        .pop             (pop),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_last_of_tile  (o_last_of_tile),
        .o_last_of_image (o_last_of_image)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [23:0] palette_rgb(input logic [5:0] idx);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] grey;
        int         n;
        n = idx[3:0];
        case (idx[5:4])
            2'd0:    begin r = 8'h00; grey = 8'h3d; end
            2'd1:    begin r = 8'h70; grey = 8'h70; end
            2'd2:    begin r = 8'hc0; grey = 8'ha8; end
            default: begin r = 8'hff; grey = 8'hd7; end
        endcase
        case (n / 3)
            0:       g = 8'h00;
            1:       g = 8'h60;
            2:       g = 8'h9c;
            3:       g = 8'hd0;
            default: g = 8'hff;
        endcase
        case (n % 3)
            0:       b = 8'h00;
            1:       b = 8'ha0;
            default: b = 8'hff;
        endcase
        if (n == 15) begin
            r = grey;
            g = grey;
            b = grey;
        end
        return {r, g, b};
    endfunction

    function automatic logic [7:0] alpha_level(input logic [1:0] code);
        case (code)
            2'd0:    return 8'h00;
            2'd1:    return 8'h3d;
            2'd2:    return 8'h80;
            default: return 8'hff;
        endcase
    endfunction

    function automatic logic [31:0] tile_word(input logic [15:0] mask, input logic [5:0] fg,
                                              input logic [1:0] fa, input logic [5:0] bg,
                                              input logic [1:0] ba);
        return {ba, bg, fa, fg, mask};
    endfunction

    function automatic logic [11:0] any_origin();
        case ($urandom_range(0, 5))
            0:       return 12'h800;
            1:       return 12'h7ff;
            default: return 12'($urandom());
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 6;
        endcase
    endfunction

    // walks the image for one accepted word and queues the pixels it yields
    task automatic expand_word(input logic [31:0] w, input logic s);
        pixel_t      px;
        logic        on;
        logic        fin_col;
        logic        fin_row;
        logic        pick;
        logic [23:0] rgb;
        int          bx;
        int          by;
        if (s) begin
            img_high = w[7:0];
            img_wide = w[15:8];
            tile_col = '0;
            tile_row = '0;
            frame_no = '0;
            img_on   = (w[7:0] != 0) && (w[15:8] != 0);
            return;
        end
        if (!img_on)
            return;
        fin_col = (int'(tile_col) + 1 >= int'(img_wide));
        fin_row = (int'(tile_row) + 1 >= int'(img_high));
        pick    = (frame_no == sel_frame);
        if (pick) begin
            bx = int'($signed(org_x)) + 4 * int'(tile_col);
            by = int'($signed(org_y)) + 4 * int'(tile_row);
            for (int i = 0; i < 16; i++) begin
                on           = w[i];
                rgb          = palette_rgb(on ? w[21:16] : w[29:24]);
                px.x         = 13'(bx + i % 4);
                px.y         = 13'(by + i / 4);
                px.r         = rgb[23:16];
                px.g         = rgb[15:8];
                px.b         = rgb[7:0];
                px.a         = alpha_level(on ? w[23:22] : w[31:30]);
                px.tile_end  = (i == 15);
                px.image_end = (i == 15) && fin_col && fin_row;
                due_pixels.push_back(px);
            end
        end
        if (fin_col) begin
            tile_col = '0;
            if (fin_row) begin
                tile_row = '0;
                if (pick)
                    img_on = 1'b0;
                else
                    frame_no = frame_no + 8'd1;
            end else begin
                tile_row = tile_row + 8'd1;
            end
        end else begin
            tile_col = tile_col + 8'd1;
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin : driver
        image_beat_t nxt;
        logic        push_nxt;
        push_nxt = push;
        if (i_rst_n) begin
            if (push && !full) begin
                expand_word(i_image_word, i_start_of_image);
                push_nxt = 1'b0;
            end
            if (!push_nxt) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_beats.size() > 0) begin
                    if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
                        send_gap = $urandom_range(0, 6);
                    end else begin
                        nxt = queued_beats.pop_front();
                        i_image_word     <= nxt.word;
                        i_start_of_image <= nxt.start;
                        push_nxt = 1'b1;
                    end
                end
            end
        end
        push <= push_nxt;
    end

    // receiver and checker
    always @(posedge i_clk) begin : monitor
        pixel_t want;
        if (i_rst_n && pop && !empty) begin
            if (due_pixels.size() == 0) begin
                $display("%0t unexpected pixel beat: expected none, actual x=%0d y=%0d",
                         $time, o_pixel_x, o_pixel_y);
                mismatches++;
            end else begin
                want = due_pixels.pop_front();
                check_field("pixel_x", want.x, o_pixel_x);
                check_field("pixel_y", want.y, o_pixel_y);
                check_field("red", want.r, o_red);
                check_field("green", want.g, o_green);
                check_field("blue", want.b, o_blue);
                check_field("alpha", want.a, o_alpha);
                check_field("last_of_tile", want.tile_end, o_last_of_tile);
                check_field("last_of_image", want.image_end, o_last_of_image);
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap--;
            pop <= 1'b0;
        end else if (take_odds != 0 && $urandom_range(1, take_odds) == 1) begin
            take_gap = $urandom_range(0, 6);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_word(input logic [31:0] w, input logic s);
        image_beat_t bt;
        bt.word  = w;
        bt.start = s;
        queued_beats.push_back(bt);
    endtask

    task automatic set_reg(input t_cfg_index idx, input logic [11:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_FRAME_SELECT: sel_frame = val[7:0];
            CFG_X_ORIGIN:     org_x = val;
            CFG_Y_ORIGIN:     org_y = val;
            default:          ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block idle: nothing queued, nothing in flight, no pixel owed
    task automatic drain();
        while (queued_beats.size() != 0 || push || due_pixels.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic random_phase(input int target);
        int made;
        int kind;
        int w;
        int h;
        int total;
        int cut;
        made = 0;
        while (leftover > 0) begin
            queue_word($urandom(), 1'b0);
            leftover--;
            made++;
        end
        while (made < target) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                queue_word($urandom(), 1'b0);
                made++;
            end else if (kind == 1) begin
                w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 255);
                h = (w == 0) ? $urandom_range(0, 255) : 0;
                queue_word({16'($urandom()), 8'(w), 8'(h)}, 1'b1);
                queue_word($urandom(), 1'b0);
                made += 2;
            end else if (kind == 2) begin
                w = $urandom_range(200, 255);
                h = $urandom_range(1, 255);
                queue_word({16'($urandom()), 8'(w), 8'(h)}, 1'b1);
                total = $urandom_range(1, 4);
                repeat (total) queue_word($urandom(), 1'b0);
                made += total + 1;
            end else begin
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 3);
                total = w * h * (int'(sel_frame) + 1);
                if ($urandom_range(0, 3) == 0)
                    total += $urandom_range(1, 3);
                queue_word({16'($urandom()), 8'(w), 8'(h)}, 1'b1);
                cut = total;
                if ($urandom_range(0, 4) == 0) begin
                    cut = $urandom_range(1, total);
                    leftover = total - cut;
                end
                repeat (cut) queue_word($urandom(), 1'b0);
                made += cut + 1;
                if (leftover > 0)
                    break;
            end
        end
        rand_words += made;
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty dimensions, stray tiles, single tile image, colour extremes
        set_reg(CFG_FRAME_SELECT, 12'd0);
        set_reg(CFG_X_ORIGIN, 12'd0);
        set_reg(CFG_Y_ORIGIN, 12'd0);
        @(negedge i_clk);
        queue_word(32'h1234_5678, 1'b0);
        queue_word(32'h0000_0005, 1'b1);
        queue_word(32'hffff_ffff, 1'b0);
        queue_word(32'h0000_0300, 1'b1);
        queue_word(32'hffff_ffff, 1'b0);
        queue_word(32'h0000_0101, 1'b1);
        queue_word(tile_word(16'hffff, 6'd63, 2'd3, 6'd0, 2'd0), 1'b0);
        queue_word(32'hffff_ffff, 1'b0);
        queue_word(32'hffff_0202, 1'b1);
        queue_word(32'h0000_0000, 1'b0);
        queue_word(tile_word(16'h0000, 6'd0, 2'd0, 6'd63, 2'd3), 1'b0);
        queue_word(tile_word(16'ha5a5, 6'd15, 2'd1, 6'd47, 2'd2), 1'b0);
        queue_word(tile_word(16'h8001, 6'd31, 2'd2, 6'd14, 2'd1), 1'b0);
        drain();

        // origin extremes, restart mid-image, unselected frame
        set_reg(CFG_FRAME_SELECT, 12'd1);
        set_reg(CFG_X_ORIGIN, 12'h800);
        set_reg(CFG_Y_ORIGIN, 12'h7ff);
        @(negedge i_clk);
        queue_word(32'h0000_0201, 1'b1);
        queue_word($urandom(), 1'b0);
        queue_word(32'h0000_0102, 1'b1);
        repeat (4) queue_word($urandom(), 1'b0);
        drain();

        // largest header, then an image left half done
        set_reg(CFG_FRAME_SELECT, 12'd0);
        set_reg(CFG_X_ORIGIN, 12'h7ff);
        set_reg(CFG_Y_ORIGIN, 12'h800);
        @(negedge i_clk);
        queue_word(32'h0000_ffff, 1'b1);
        repeat (2) queue_word($urandom(), 1'b0);
        queue_word(32'h0000_0202, 1'b1);
        repeat (2) queue_word($urandom(), 1'b0);
        drain();

        // origins moved while the image is open
        set_reg(CFG_X_ORIGIN, 12'h010);
        set_reg(CFG_Y_ORIGIN, 12'hf00);
        @(negedge i_clk);
        repeat (2) queue_word($urandom(), 1'b0);
        drain();

        // frame counter wrap with frame_select lowered under it
        set_reg(CFG_FRAME_SELECT, 12'd255);
        @(negedge i_clk);
        queue_word(32'h0000_0101, 1'b1);
        repeat (3) queue_word($urandom(), 1'b0);
        drain();
        set_reg(CFG_FRAME_SELECT, 12'd1);
        @(negedge i_clk);
        repeat (255) queue_word($urandom(), 1'b0);
        drain();

        while (rand_words < 100) begin
            send_odds = pick_odds();
            take_odds = pick_odds();
            if ($urandom_range(0, 1))
                set_reg(CFG_FRAME_SELECT, 12'($urandom_range(0, 2)));
            if ($urandom_range(0, 1))
                set_reg(CFG_X_ORIGIN, any_origin());
            if ($urandom_range(0, 1))
                set_reg(CFG_Y_ORIGIN, any_origin());
            @(negedge i_clk);
            random_phase($urandom_range(15, 50));
            drain();
        end

        // closing stretch at full rate
        send_odds = 0;
        take_odds = 0;
        set_reg(CFG_FRAME_SELECT, 12'($urandom_range(0, 1)));
        @(negedge i_clk);
        random_phase(50);
        drain();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
